[sv/battery_voltage_capacity_gauge_core_defines.svh]
// ----------------------------------------------------------------------------
// Battery gauge assertion macros
// Shared property wrappers for the gauge RTL.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_CAPACITY_GAUGE_CORE_DEFINES_SVH
`define BATTERY_VOLTAGE_CAPACITY_GAUGE_CORE_DEFINES_SVH

// same-cycle implication
`define BVCG_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gauge assertion failed");

// next-cycle implication
`define BVCG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gauge assertion failed");

`endif

[sv/bvcg_pkg.sv]
// ----------------------------------------------------------------------------
// Battery gauge package
// Widths, constants and shared types of the battery gauge.
// ----------------------------------------------------------------------------
`default_nettype none

package bvcg_pkg;

   localparam int ADC_BITS   = 12;
   localparam int SAMPLE_W   = 12;
   localparam int SUM_W      = 20;
   localparam int COUNT_W    = 8;
   localparam int CFG_W      = 16;
   localparam int MV_W       = 19;
   localparam int PCT_W      = 7;
   localparam int CSR_IDX_W  = 3;

   localparam int DIV_W      = 36;
   localparam int DIVISOR_W  = 16;
   localparam int STEP_W     = 6;
   localparam int PCT_NUM_W  = 23;

   localparam int MUL_A_W    = 29;
   localparam int MUL_B_W    = 30;
   localparam int MUL_W      = MUL_A_W + MUL_B_W;
   localparam int RCP_SHIFT  = 39;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
      (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

   localparam logic [SUM_W-1:0]     SUM_MAX    = {SUM_W{1'b1}};
   localparam logic [MV_W-1:0]      VOLT_MAX   = {MV_W{1'b1}};
   localparam logic [DIVISOR_W-1:0] UV_PER_MV  = DIVISOR_W'(1000);
   localparam logic [PCT_W-1:0]     FULL_PCT   = PCT_W'(100);

   // x / 1000 == (x * RCP_MULT) >> RCP_SHIFT for every x below 2**29
   localparam logic [MUL_B_W-1:0]   RCP_MULT   = MUL_B_W'(549755814);
   // scaled products at or above this give a saturated voltage
   localparam logic [DIV_W-1:0]     MV_SAT_PROD = DIV_W'(524288000);

   localparam logic [STEP_W-1:0] STEPS_AVG = STEP_W'(SUM_W);
   localparam logic [STEP_W-1:0] STEPS_PCT = STEP_W'(PCT_NUM_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLES      = 3'd0,
      CSR_UV_PER_COUNT = 3'd1,
      CSR_NO_BATT      = 3'd2,
      CSR_EMPTY        = 3'd3,
      CSR_FULL         = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0] samples_per_reading;
      logic [CFG_W-1:0]   microvolts_per_count;
      logic [CFG_W-1:0]   no_battery_limit_mv;
      logic [CFG_W-1:0]   empty_level_mv;
      logic [CFG_W-1:0]   full_level_mv;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
      logic [STEP_W-1:0]    steps;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_stat_type;

endpackage

`default_nettype wire

[sv/battery_voltage_capacity_gauge_core.sv]
// ----------------------------------------------------------------------------
// Battery voltage and capacity gauge
// Averages ADC samples and reports voltage in mV and capacity in percent.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_stall  | req_adc_sample
//  rsp     | out | rsp_valid/rsp_stall  | rsp_voltage_mv, rsp_capacity_pct
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
//  A sample that does not close a reading only updates the running sum and count.
//  A closing sample computes a reading, with a second division when the
//  voltage falls in the linear range: the shared divider runs 20 steps for
//  the average and 23 for the percentage; mV scaling is a reciprocal multiply.
//  req_stall is high while a reading is computed or its result cannot be
//  stored because the previous result is still stalled.
//  Synchronous active high reset; configuration resets to one sample, zero scale.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_capacity_gauge_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bvcg_pkg::SAMPLE_W-1:0]  req_adc_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bvcg_pkg::MV_W-1:0]      rsp_voltage_mv,
   output logic [bvcg_pkg::PCT_W-1:0]     rsp_capacity_pct,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bvcg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bvcg_pkg::CFG_W-1:0]     csr_data
);
   import bvcg_pkg::*;

   `include "battery_voltage_capacity_gauge_core_defines.svh"

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG,
      ST_MUL,
      ST_MV,
      ST_CAP,
      ST_PCT_GO,
      ST_PCT,
      ST_OUT
   } state_type;

   cfg_type      cfg;
   div_req_type  div_req;
   div_stat_type div_stat;

   state_type          state_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [COUNT_W-1:0] taken_ff;
   logic [SUM_W-1:0]   avg_ff;
   logic [DIV_W-1:0]   prod_ff;
   logic [MV_W-1:0]    mv_ff;
   logic [PCT_W-1:0]   cap_ff;
   logic               rsp_valid_ff;
   logic [MV_W-1:0]    rsp_mv_ff;
   logic [PCT_W-1:0]   rsp_cap_ff;

   logic [SAMPLE_W-1:0] sample;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    sum_in;
   logic [COUNT_W-1:0]  taken_in;
   logic [COUNT_W-1:0]  count;
   logic                accept;
   logic                closes;
   logic                out_free;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_W-1:0]    mul_p;
   logic [MV_W-1:0]     mv_sat;
   logic [CFG_W-1:0]    span;
   logic [MV_W-1:0]     mv_off;

   bvcg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bvcg_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_stat (div_stat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign sample   = req_adc_sample & SAMPLE_MASK;
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(sample);
   assign sum_in   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
   assign taken_in = taken_ff + COUNT_W'(1);
   assign count    = (cfg.samples_per_reading == '0) ? COUNT_W'(1)
                                                     : cfg.samples_per_reading;
   assign closes   = (taken_in == '0) || (taken_in >= count);

   assign span   = cfg.full_level_mv - cfg.empty_level_mv;
   assign mv_off = mv_ff - MV_W'(cfg.empty_level_mv);

   // shared multiplier: avg * scale, then reciprocal of 1000, then (mv - empty) * 100
   assign mul_a = (state_ff == ST_CAP) ? MUL_A_W'(mv_off) :
                  (state_ff == ST_MV)  ? prod_ff[MUL_A_W-1:0] : MUL_A_W'(avg_ff);
   assign mul_b = (state_ff == ST_CAP) ? MUL_B_W'(FULL_PCT) :
                  (state_ff == ST_MV)  ? RCP_MULT : MUL_B_W'(cfg.microvolts_per_count);
   assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

   assign mv_sat = (prod_ff >= MV_SAT_PROD) ? VOLT_MAX : mul_p[RCP_SHIFT +: MV_W];

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {sum_in, {(DIV_W - SUM_W){1'b0}}};
      div_req.divisor  = DIVISOR_W'(count);
      div_req.steps    = STEPS_AVG;
      unique case (state_ff)
         ST_IDLE: begin
            div_req.start = accept && closes;
         end
         ST_PCT_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {prod_ff[PCT_NUM_W-1:0], {(DIV_W - PCT_NUM_W){1'b0}}};
            div_req.divisor  = span;
            div_req.steps    = STEPS_PCT;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (closes) begin
                     sum_ff   <= '0;
                     taken_ff <= '0;
                     state_ff <= ST_AVG;
                  end else begin
                     sum_ff   <= sum_in;
                     taken_ff <= taken_in;
                  end
               end
            end
            ST_AVG: begin
               if (div_stat.done) begin
                  avg_ff   <= div_stat.quotient[SUM_W-1:0];
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= mul_p[DIV_W-1:0];
               state_ff <= ST_MV;
            end
            ST_MV: begin
               mv_ff    <= mv_sat;
               state_ff <= ST_CAP;
            end
            ST_CAP: begin
               if (mv_ff <= MV_W'(cfg.no_battery_limit_mv)) begin
                  cap_ff   <= FULL_PCT;
                  state_ff <= ST_OUT;
               end else if (mv_ff < MV_W'(cfg.empty_level_mv)) begin
                  cap_ff   <= '0;
                  state_ff <= ST_OUT;
               end else if (mv_ff <= MV_W'(cfg.full_level_mv) && span != '0) begin
                  prod_ff  <= mul_p[DIV_W-1:0];
                  state_ff <= ST_PCT_GO;
               end else begin
                  cap_ff   <= FULL_PCT;
                  state_ff <= ST_OUT;
               end
            end
            ST_PCT_GO: begin
               state_ff <= ST_PCT;
            end
            ST_PCT: begin
               if (div_stat.done) begin
                  cap_ff   <= div_stat.quotient[PCT_W-1:0];
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_mv_ff    <= mv_ff;
                  rsp_cap_ff   <= cap_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_voltage_mv   = rsp_mv_ff;
   assign rsp_capacity_pct = rsp_cap_ff;

   `BVCG_ASSERT_IMPL(a_busy_not_idle, clock, reset, div_stat.busy, state_ff != ST_IDLE)
   `BVCG_ASSERT_IMPL(a_done_waiting, clock, reset, div_stat.done, (state_ff == ST_AVG) || (state_ff == ST_PCT))
   `BVCG_ASSERT_IMPL(a_cap_range, clock, reset, rsp_valid_ff, rsp_cap_ff <= FULL_PCT)
   `BVCG_ASSERT_NEXT(a_close_starts, clock, reset, accept && closes, div_stat.busy)

endmodule

`default_nettype wire

[sv/bvcg_csr.sv]
// ----------------------------------------------------------------------------
// Battery gauge register bank
// Holds the five configuration registers written over the csr channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bvcg_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bvcg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bvcg_pkg::CFG_W-1:0]     csr_data,
   output bvcg_pkg::cfg_type              cfg
);
   import bvcg_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.samples_per_reading  <= COUNT_W'(1);
         cfg_ff.microvolts_per_count <= '0;
         cfg_ff.no_battery_limit_mv  <= '0;
         cfg_ff.empty_level_mv       <= '0;
         cfg_ff.full_level_mv        <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLES:      cfg_ff.samples_per_reading  <= csr_data[COUNT_W-1:0];
            CSR_UV_PER_COUNT: cfg_ff.microvolts_per_count <= csr_data;
            CSR_NO_BATT:      cfg_ff.no_battery_limit_mv  <= csr_data;
            CSR_EMPTY:        cfg_ff.empty_level_mv       <= csr_data;
            CSR_FULL:         cfg_ff.full_level_mv        <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

[sv/bvcg_divider.sv]
// ----------------------------------------------------------------------------
// Battery gauge divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bvcg_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  bvcg_pkg::div_req_type  div_req,
   output bvcg_pkg::div_stat_type div_stat
);
   import bvcg_pkg::*;

   `include "battery_voltage_capacity_gauge_core_defines.svh"

   logic                 busy_ff;
   logic                 done_ff;
   logic [STEP_W-1:0]    cnt_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] dsr_ff;
   logic [DIV_W-1:0]     quo_ff;

   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;
   logic [DIVISOR_W-1:0] rem_in;

   // dividend is left aligned; quotient bits shift in from the bottom
   assign trial  = {rem_ff, quo_ff[DIV_W-1]};
   assign diff   = trial - {1'b0, dsr_ff};
   assign fits   = (trial >= {1'b0, dsr_ff});
   assign rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= div_req.steps;
            rem_ff  <= '0;
            dsr_ff  <= div_req.divisor;
            quo_ff  <= div_req.dividend;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_stat.busy     = busy_ff;
   assign div_stat.done     = done_ff;
   assign div_stat.quotient = quo_ff;

   `BVCG_ASSERT_IMPL(a_no_start_busy, clock, reset, div_req.start, !busy_ff)
   `BVCG_ASSERT_IMPL(a_rem_below_dsr, clock, reset, busy_ff, rem_ff < dsr_ff)
   `BVCG_ASSERT_IMPL(a_done_not_busy, clock, reset, done_ff, !busy_ff)
   `BVCG_ASSERT_IMPL(a_busy_count, clock, reset, busy_ff, cnt_ff != '0)

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Battery gauge testbench
// Drives ADC samples and register writes into the gauge with random idle
// gaps on the samples and random stall bursts on the responses, predicts
// every reading from a copy of the averaging and capacity mapping, and checks it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bvcg_pkg::*;

   localparam int RANDOM_ITEMS = 1000;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 120;
   localparam int WATCHDOG     = 3000;

   typedef struct packed {
      logic [MV_W-1:0]  mv;
      logic [PCT_W-1:0] pct;
   } reading_type;

   class gauge_readings;
      cfg_type            regs;
      logic [SUM_W-1:0]   sum_acc;
      logic [COUNT_W-1:0] taken;
      reading_type        due_readings[$];
      int                 errors;

      function new();
         regs                      = '0;
         regs.samples_per_reading  = COUNT_W'(1);
         sum_acc                   = '0;
         taken                     = '0;
         errors                    = 0;
      endfunction

      function void note_write(csr_index_type idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_SAMPLES:      regs.samples_per_reading  = data[COUNT_W-1:0];
            CSR_UV_PER_COUNT: regs.microvolts_per_count = data;
            CSR_NO_BATT:      regs.no_battery_limit_mv  = data;
            CSR_EMPTY:        regs.empty_level_mv       = data;
            CSR_FULL:         regs.full_level_mv        = data;
            default: ;
         endcase
      endfunction

      function logic [PCT_W-1:0] capacity_for(longint unsigned mv);
         longint unsigned lo, hi, span;
         lo = longint'(regs.empty_level_mv);
         hi = longint'(regs.full_level_mv);
         if (mv <= longint'(regs.no_battery_limit_mv)) return FULL_PCT;
         if (mv < lo) return '0;
         if (mv <= hi) begin
            span = hi - lo;
            if (span == 0) return FULL_PCT;
            return PCT_W'((mv - lo) * longint'(FULL_PCT) / span);
         end
         return FULL_PCT;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] raw);
         longint unsigned total, cnt, avg, mv;
         reading_type     r;
         cnt = (regs.samples_per_reading == 0) ? 1 : longint'(regs.samples_per_reading);
         total = longint'(sum_acc) + longint'(raw & SAMPLE_MASK);
         if (total > longint'(SUM_MAX)) total = longint'(SUM_MAX);
         sum_acc = SUM_W'(total);
         taken = taken + 1'b1;
         if (taken != 0 && longint'(taken) < cnt) return;
         avg = total / cnt;
         mv = avg * longint'(regs.microvolts_per_count) / longint'(UV_PER_MV);
         if (mv > longint'(VOLT_MAX)) mv = longint'(VOLT_MAX);
         r.mv  = MV_W'(mv);
         r.pct = capacity_for(mv);
         due_readings.push_back(r);
         sum_acc = '0;
         taken   = '0;
      endfunction

      function void check_reading(logic [MV_W-1:0] mv, logic [PCT_W-1:0] pct);
         reading_type want;
         if (due_readings.size() == 0) begin
            $display("%0t: unexpected reading mv %0d pct %0d", $time, mv, pct);
            errors++;
            return;
         end
         want = due_readings.pop_front();
         if (mv !== want.mv) begin
            $display("%0t: voltage_mv expected %0d actual %0d", $time, want.mv, mv);
            errors++;
         end
         if (pct !== want.pct) begin
            $display("%0t: capacity_pct expected %0d actual %0d", $time, want.pct, pct);
            errors++;
         end
      endfunction

      function int pending();
         return due_readings.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [SAMPLE_W-1:0]  req_adc_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [MV_W-1:0]      rsp_voltage_mv;
   logic [PCT_W-1:0]     rsp_capacity_pct;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SAMPLES;
   logic [CFG_W-1:0]     csr_data = '0;

   bit                   idle_on = 1'b1;
   logic [7:0]           hold_seq = '0;
   logic [7:0]           hold_seen = '0;
   int                   hold_left = 0;
   int                   stall_left = 0;
   int                   quiet_cycles = 0;

   gauge_readings gauge = new();

   battery_voltage_capacity_gauge_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adc_sample   (req_adc_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_voltage_mv   (rsp_voltage_mv),
      .rsp_capacity_pct (rsp_capacity_pct),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: long hold on request, else random stall bursts
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) gauge.check_reading(rsp_voltage_mv, rsp_capacity_pct);
         if (csr_valid && csr_ready) gauge.note_write(csr_index_type'(csr_index), csr_data);
         if (req_valid && !req_stall) gauge.note_sample(req_adc_sample);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((rsp_valid && !rsp_stall) || (csr_valid && csr_ready) ||
             (req_valid && !req_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG) begin
            $display("%0t: no progress", $time);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit allow_gap);
      if (allow_gap && idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_config(input logic [COUNT_W-1:0] spr, input logic [CFG_W-1:0] uv,
                              input logic [CFG_W-1:0] nb, input logic [CFG_W-1:0] lo,
                              input logic [CFG_W-1:0] hi);
      write_reg(CSR_SAMPLES, CFG_W'(spr));
      write_reg(CSR_UV_PER_COUNT, uv);
      write_reg(CSR_NO_BATT, nb);
      write_reg(CSR_EMPTY, lo);
      write_reg(CSR_FULL, hi);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (gauge.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return {SAMPLE_W{1'b1}};
         default: return SAMPLE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   initial begin : stimulus
      int unsigned sent, n, cnt, k, r;
      int          spr, uv, nb, lo, hi, tmp;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // mV equals the sample: walk through every capacity region
      load_config(1, 1000, 100, 1000, 3000);
      send_sample(0, 1);
      send_sample(4095, 1);
      send_sample(50, 1);
      send_sample(100, 1);
      send_sample(101, 1);
      send_sample(1000, 1);
      send_sample(2000, 1);
      send_sample(2999, 1);
      send_sample(3000, 1);
      drain();

      // zero count, zero-width range
      load_config(0, 1000, 0, 2000, 2000);
      send_sample(2000, 1);
      send_sample(1999, 1);
      send_sample(2001, 1);
      drain();

      // empty level above full level
      load_config(0, 1000, 500, 3000, 1000);
      send_sample(2500, 1);
      send_sample(3000, 1);
      send_sample(600, 1);
      send_sample(400, 1);
      drain();

      // count lowered in the middle of a reading
      load_config(8, 2000, 0, 100, 8000);
      send_sample(4095, 1);
      send_sample(4095, 1);
      send_sample(0, 1);
      send_sample(4095, 1);
      send_sample(1234, 1);
      drain();
      write_reg(CSR_SAMPLES, 3);
      csr_valid <= 1'b0;
      send_sample(777, 1);
      drain();

      // full output buffer under a long response hold, then a full pause
      load_config(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      hold_seq <= hold_seq + 1'b1;
      for (k = 0; k < 12; k++) send_sample(pick_sample(), 0);
      req_valid <= 1'b0;
      @(posedge clock);
      while (gauge.pending() != 0) @(posedge clock);
      for (k = 0; k < 6; k++) send_sample(pick_sample(), 1);
      drain();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 15);
         if (r == 0) spr = 0;
         else if (r == 1) spr = 255;
         else if (r == 2) spr = $urandom_range(9, 40);
         else spr = $urandom_range(1, 8);
         r = $urandom_range(0, 7);
         if (r == 0) uv = 16'hFFFF;
         else if (r == 1) uv = 0;
         else if (r == 2) uv = $urandom_range(0, 65535);
         else uv = $urandom_range(200, 16000);
         nb = $urandom_range(0, 3000);
         lo = $urandom_range(nb, 40000);
         hi = lo + $urandom_range(0, 25000);
         case ($urandom_range(0, 7))
            0: begin
               nb = $urandom_range(0, 65535);
               lo = $urandom_range(0, 65535);
               hi = $urandom_range(0, 65535);
            end
            1: hi = lo;
            2: begin
               tmp = lo;
               lo  = hi + 1;
               hi  = tmp;
            end
            3: begin
               nb = 16'hFFFF;
               lo = 16'hFFFF;
               hi = 16'hFFFF;
            end
            default: ;
         endcase
         load_config(COUNT_W'(spr), CFG_W'(uv), CFG_W'(nb), CFG_W'(lo), CFG_W'(hi));
         cnt = (spr == 0) ? 1 : spr;
         if (cnt > 40) n = cnt + $urandom_range(0, cnt - 1);
         else n = cnt * $urandom_range(2, 6) + $urandom_range(0, cnt - 1);
         for (k = 0; k < n && sent < RANDOM_ITEMS; k++) begin
            send_sample(pick_sample(), 1);
            sent++;
            if (sent > RANDOM_ITEMS * 85 / 100) idle_on <= 1'b0;
         end
         drain();
      end

      if (gauge.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
